@@ rtl/spm_pkg.sv @@
// Package for the stroke point merger: field widths and defaults for the
// interfaces and modules, and the control state type of the top level.
// No dependencies.
package spm_pkg;

    // Field widths
    localparam int XY_W        = 24;   // point coordinates, signed
    localparam int P_W         = 16;   // pressure, unsigned fraction
    localparam int MD_W        = 23;   // merge radius register
    localparam int SUM_W       = 32;   // pressure group sum

    // Bit-serial distance datapath
    localparam int DX_W        = 24;   // |dx| and |dy| never exceed 2^24 - 1
    localparam int TERM_W      = 26;   // dx + dy - md for one bit position
    localparam int ACC_W       = 50;   // signed d2 - r2

    // Default width of the group counter
    localparam int COUNT_BITS_DEF = 16;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

endpackage

@@ rtl/spm_ifs.sv @@
// Valid/ready channel interfaces for stroke points in and kept points out.
// Depends on spm_pkg for the field widths.
interface spm_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [spm_pkg::XY_W-1:0]   point_x;
    logic signed [spm_pkg::XY_W-1:0]   point_y;
    logic        [spm_pkg::P_W-1:0]    pressure;
    logic                              stroke_end;

    modport source (output valid, point_x, point_y, pressure, stroke_end, input ready);
    modport sink   (input valid, point_x, point_y, pressure, stroke_end, output ready);
endinterface

interface spm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [spm_pkg::XY_W-1:0]   out_x;
    logic signed [spm_pkg::XY_W-1:0]   out_y;
    logic        [spm_pkg::P_W-1:0]    out_pressure;
    logic                              out_last;

    modport source (output valid, out_x, out_y, out_pressure, out_last, input ready);
    modport sink   (input valid, out_x, out_y, out_pressure, out_last, output ready);
endinterface

@@ rtl/spm_dist.sv @@
// Bit-serial squared distance test: decides dx^2 + dy^2 < md^2, one
// multiplier bit per cycle, MSB first. Depends on spm_pkg.
module spm_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [spm_pkg::XY_W-1:0]   i_x,
    input  logic signed [spm_pkg::XY_W-1:0]   i_y,
    input  logic signed [spm_pkg::XY_W-1:0]   i_kept_x,
    input  logic signed [spm_pkg::XY_W-1:0]   i_kept_y,
    input  logic        [spm_pkg::MD_W-1:0]   i_min_distance,
    output logic                              o_busy,
    output logic                              o_done,
    output logic                              o_merge
);

    localparam int CNT_W = $clog2(spm_pkg::DX_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(spm_pkg::DX_W - 1);

    logic signed [spm_pkg::XY_W:0]      w_diff_x;
    logic signed [spm_pkg::XY_W:0]      w_diff_y;
    logic        [spm_pkg::XY_W:0]      w_abs_x;
    logic        [spm_pkg::XY_W:0]      w_abs_y;

    logic        [spm_pkg::DX_W-1:0]    r_dx;
    logic        [spm_pkg::DX_W-1:0]    r_dy;
    logic        [spm_pkg::DX_W-1:0]    r_md;
    logic        [spm_pkg::DX_W-1:0]    r_dx_sh;
    logic        [spm_pkg::DX_W-1:0]    r_dy_sh;
    logic        [spm_pkg::DX_W-1:0]    r_md_sh;
    logic signed [spm_pkg::ACC_W-1:0]   r_acc;
    logic signed [spm_pkg::ACC_W-1:0]   n_acc;
    logic        [CNT_W-1:0]            r_cnt;
    logic                               r_busy;
    logic                               r_done;
    logic                               r_merge;

    logic        [spm_pkg::DX_W-1:0]    w_sel_dx;
    logic        [spm_pkg::DX_W-1:0]    w_sel_dy;
    logic        [spm_pkg::DX_W-1:0]    w_sel_md;
    logic signed [spm_pkg::TERM_W-1:0]  w_term;

    // Absolute coordinate differences, taken on the start cycle
    assign w_diff_x = (spm_pkg::XY_W+1)'(i_x) - (spm_pkg::XY_W+1)'(i_kept_x);
    assign w_diff_y = (spm_pkg::XY_W+1)'(i_y) - (spm_pkg::XY_W+1)'(i_kept_y);
    assign w_abs_x  = w_diff_x[spm_pkg::XY_W] ? -w_diff_x : w_diff_x;
    assign w_abs_y  = w_diff_y[spm_pkg::XY_W] ? -w_diff_y : w_diff_y;

    // One bit of each square and of the radius square per cycle
    assign w_sel_dx = r_dx_sh[spm_pkg::DX_W-1] ? r_dx : '0;
    assign w_sel_dy = r_dy_sh[spm_pkg::DX_W-1] ? r_dy : '0;
    assign w_sel_md = r_md_sh[spm_pkg::DX_W-1] ? r_md : '0;
    assign w_term   = spm_pkg::TERM_W'(w_sel_dx) + spm_pkg::TERM_W'(w_sel_dy)
                    - spm_pkg::TERM_W'(w_sel_md);
    assign n_acc    = (r_acc <<< 1) + spm_pkg::ACC_W'(w_term);

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx    <= spm_pkg::DX_W'(w_abs_x);
            r_dy    <= spm_pkg::DX_W'(w_abs_y);
            r_md    <= spm_pkg::DX_W'(i_min_distance);
            r_dx_sh <= spm_pkg::DX_W'(w_abs_x);
            r_dy_sh <= spm_pkg::DX_W'(w_abs_y);
            r_md_sh <= spm_pkg::DX_W'(i_min_distance);
            r_acc   <= '0;
        end else if (r_busy) begin
            r_dx_sh <= r_dx_sh << 1;
            r_dy_sh <= r_dy_sh << 1;
            r_md_sh <= r_md_sh << 1;
            r_acc   <= n_acc;
            // d2 below r2 leaves the difference negative
            if (r_cnt == LAST_BIT) begin
                r_merge <= n_acc[spm_pkg::ACC_W-1];
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_merge = r_merge;

`ifndef SYNTH
    // A new test never starts over one in progress
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("distance test restarted while busy");
    // Done is raised in the cycle after the last bit step
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == LAST_BIT) |=> (r_done && !r_busy))
        else $error("distance done not raised after last bit");
    // Done comes only after a run
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("distance done without a run");
`endif

endmodule

@@ rtl/spm_div.sv @@
// Restoring divider for the group average: sum / count, saturated to the
// pressure range, one quotient bit per cycle. Depends on spm_pkg.
module spm_div #(
    parameter int COUNT_BITS = spm_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [spm_pkg::SUM_W-1:0]     i_sum,
    input  logic [COUNT_BITS-1:0]         i_count,
    output logic                          o_busy,
    output logic [spm_pkg::P_W-1:0]       o_quot
);

    localparam int CNT_W = $clog2(spm_pkg::P_W);
    localparam int MW    = COUNT_BITS + spm_pkg::P_W;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(spm_pkg::P_W - 1);

    logic [COUNT_BITS-1:0]        w_div;
    logic [spm_pkg::P_W-1:0]      w_sum_hi;
    logic                         w_ovf;

    logic [COUNT_BITS-1:0]        r_div;
    logic [COUNT_BITS-1:0]        r_rem;
    logic [spm_pkg::P_W-1:0]      r_dvd;
    logic [spm_pkg::P_W-1:0]      r_quot;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;

    logic [COUNT_BITS:0]          w_trial;
    logic                         w_fit;
    logic [COUNT_BITS:0]          w_diff;

    // An empty group divides by one
    assign w_div    = (i_count != '0) ? i_count : COUNT_BITS'(1);
    assign w_sum_hi = i_sum[spm_pkg::SUM_W-1:spm_pkg::SUM_W-spm_pkg::P_W];
    // Quotient overflows the pressure range when sum >= div * 2^16
    assign w_ovf    = MW'(w_sum_hi) >= MW'(w_div);

    // Trial subtract of one remainder step
    assign w_trial  = {r_rem, r_dvd[spm_pkg::P_W-1]};
    assign w_fit    = w_trial >= {1'b0, r_div};
    assign w_diff   = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= !w_ovf;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= w_div;
            // Without overflow the upper half is below the divisor, so it fits the remainder
            r_rem  <= COUNT_BITS'(w_sum_hi);
            r_dvd  <= i_sum[spm_pkg::P_W-1:0];
            r_quot <= w_ovf ? '1 : '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
            r_dvd  <= r_dvd << 1;
            r_quot <= {r_quot[spm_pkg::P_W-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

`ifndef SYNTH
    // The remainder stays below the divisor through every step
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("divider remainder out of range");
    // Divisor is never zero during a run
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_div != '0))
        else $error("divider running with zero divisor");
    // A run ends after exactly one step per quotient bit
    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == LAST_BIT) |=> !r_busy)
        else $error("divider run length wrong");
`endif

endmodule

@@ rtl/stroke_point_merger_unit.sv @@
// Top level of the stroke point merger: drops points within the merge
// radius of the kept point and emits the rest with the group average, or
// with their own pressure for stroke start and end points. Depends on
// spm_pkg, spm_ifs, spm_dist and spm_div.
//   channel   direction  request moves
//   i_point   in         point_x, point_y, pressure, stroke_end
//   o_point   out        out_x, out_y, out_pressure, out_last
//   i_cfg_*   in         min_distance write, no read-back
//
// A stroke start or stroke end point goes from accept through S_EMIT to the
// output register. Any other point waits in S_CALC on the bit-serial distance
// test, which steps one bit of |dx|, |dy| and the radius per cycle, while the
// divider runs alongside it; a point outside the radius then goes via S_EMIT.
// Reset is synchronous and active low; it clears the radius and group state.
// The output register holds a result while o_point is stalled, and a new
// point is still accepted; a later result waits for that register to free.
module stroke_point_merger_unit #(
    parameter int COUNT_BITS = spm_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [spm_pkg::MD_W-1:0]      i_cfg_wr_data,
    spm_in_if.sink                        i_point,
    spm_out_if.source                     o_point
);

    spm_pkg::t_state                      r_state;
    spm_pkg::t_state                      n_state;

    logic [spm_pkg::MD_W-1:0]             r_min_distance;
    logic                                 r_at_start;
    logic signed [spm_pkg::XY_W-1:0]      r_kept_x;
    logic signed [spm_pkg::XY_W-1:0]      r_kept_y;
    logic [spm_pkg::SUM_W-1:0]            r_sum;
    logic [COUNT_BITS-1:0]                r_count;

    // Accepted point
    logic signed [spm_pkg::XY_W-1:0]      r_x;
    logic signed [spm_pkg::XY_W-1:0]      r_y;
    logic [spm_pkg::P_W-1:0]              r_p;
    logic                                 r_end;

    // Output register
    logic                                 r_out_valid;
    logic signed [spm_pkg::XY_W-1:0]      r_out_x;
    logic signed [spm_pkg::XY_W-1:0]      r_out_y;
    logic [spm_pkg::P_W-1:0]              r_out_p;
    logic                                 r_out_last;

    logic                                 w_in_acc;
    logic                                 w_start;
    logic                                 w_merge_upd;
    logic                                 w_emit;

    logic                                 w_dist_busy;
    logic                                 w_dist_done;
    logic                                 w_dist_merge;
    logic                                 w_div_busy;
    logic [spm_pkg::P_W-1:0]              w_div_quot;

    logic [spm_pkg::SUM_W:0]              w_sum_add;
    logic [spm_pkg::SUM_W-1:0]            n_sum_sat;
    logic [COUNT_BITS-1:0]                n_count_sat;
    logic [spm_pkg::P_W-1:0]              w_emit_p;

    assign w_in_acc      = i_point.valid && i_point.ready;
    assign i_point.ready = (r_state == spm_pkg::S_IDLE);

    // Serial units, started on the accept cycle with the current group state
    spm_dist u_dist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_x            (i_point.point_x),
        .i_y            (i_point.point_y),
        .i_kept_x       (r_kept_x),
        .i_kept_y       (r_kept_y),
        .i_min_distance (r_min_distance),
        .o_busy         (w_dist_busy),
        .o_done         (w_dist_done),
        .o_merge        (w_dist_merge)
    );

    spm_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sum   (r_sum),
        .i_count (r_count),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes
    always_comb begin
        n_state     = r_state;
        w_start     = 1'b0;
        w_merge_upd = 1'b0;
        w_emit      = 1'b0;
        case (r_state)
            spm_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_point.stroke_end || r_at_start) begin
                        n_state = spm_pkg::S_EMIT;
                    end else begin
                        w_start = 1'b1;
                        n_state = spm_pkg::S_CALC;
                    end
                end
            end
            spm_pkg::S_CALC: begin
                if (w_dist_done) begin
                    if (w_dist_merge) begin
                        w_merge_upd = 1'b1;
                        n_state     = spm_pkg::S_IDLE;
                    end else begin
                        n_state = spm_pkg::S_EMIT;
                    end
                end
            end
            spm_pkg::S_EMIT: begin
                if (!r_out_valid || o_point.ready) begin
                    w_emit  = 1'b1;
                    n_state = spm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spm_pkg::S_IDLE;
            end
        endcase
    end

    // Saturating group sum and count for a dropped point
    assign w_sum_add   = {1'b0, r_sum} + (spm_pkg::SUM_W+1)'(r_p);
    assign n_sum_sat   = w_sum_add[spm_pkg::SUM_W] ? '1 : w_sum_add[spm_pkg::SUM_W-1:0];
    assign n_count_sat = (r_count == '1) ? r_count : r_count + 1'b1;

    // Start and end points carry their own pressure
    assign w_emit_p = (r_end || r_at_start) ? r_p : w_div_quot;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_distance <= '0;
        end else if (i_cfg_wr_en) begin
            r_min_distance <= i_cfg_wr_data;
        end
    end

    // Hold the accepted point
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x   <= i_point.point_x;
            r_y   <= i_point.point_y;
            r_p   <= i_point.pressure;
            r_end <= i_point.stroke_end;
        end
    end

    // Group state: merge a dropped point, restart on an emitted one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_kept_x   <= '0;
            r_kept_y   <= '0;
            r_sum      <= '0;
            r_count    <= '0;
        end else if (w_merge_upd) begin
            r_sum   <= n_sum_sat;
            r_count <= n_count_sat;
        end else if (w_emit) begin
            if (r_end) begin
                r_at_start <= 1'b1;
                r_sum      <= '0;
                r_count    <= '0;
            end else begin
                r_at_start <= 1'b0;
                r_kept_x   <= r_x;
                r_kept_y   <= r_y;
                r_sum      <= spm_pkg::SUM_W'(r_p);
                r_count    <= COUNT_BITS'(1);
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_point.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_x    <= r_x;
            r_out_y    <= r_y;
            r_out_p    <= w_emit_p;
            r_out_last <= r_end;
        end
    end

    assign o_point.valid        = r_out_valid;
    assign o_point.out_x        = r_out_x;
    assign o_point.out_y        = r_out_y;
    assign o_point.out_pressure = r_out_p;
    assign o_point.out_last     = r_out_last;

`ifndef SYNTH
    // At a stroke start the group is empty
    a_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_start |-> (r_sum == '0 && r_count == '0))
        else $error("group not empty at stroke start");
    // Inside a stroke the group holds at least the kept point
    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_at_start |-> (r_count != '0))
        else $error("empty group inside a stroke");
    // The average is ready once the distance test finishes
    a_div_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist_done |-> !w_div_busy)
        else $error("divider still busy at distance result");
    // The distance test runs only while the sequencer waits on it
    a_calc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dist_busy || w_dist_done) |-> (r_state == spm_pkg::S_CALC))
        else $error("distance test running outside calc state");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for stroke_point_merger_unit: directed and random pen strokes are
// checked against an in-bench model of the radius merge and group averaging.
// Depends on spm_pkg, spm_ifs and the merger RTL.
module tb;

    localparam int CNT_W        = spm_pkg::COUNT_BITS_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 50;
    localparam int PHASES       = 8;
    localparam int PHASE_POINTS = 225;
    localparam longint XY_MAX   = 64'sd8388607;
    localparam longint XY_MIN   = -64'sd8388608;

    typedef struct {
        logic signed [spm_pkg::XY_W-1:0] x;
        logic signed [spm_pkg::XY_W-1:0] y;
        logic [spm_pkg::P_W-1:0]         pressure;
        logic                            last;
    } t_stroke_point;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_wr_en;
    logic [spm_pkg::MD_W-1:0] cfg_wr_data;
    bit                       idle_on;
    int                       fail_count  = 0;
    int                       cycle_count = 0;

    // Points the block must still emit, oldest first
    t_stroke_point     kept_points_q[$];

    // Model state of the merger
    bit                              pen_at_start;
    logic signed [spm_pkg::XY_W-1:0] anchor_x;
    logic signed [spm_pkg::XY_W-1:0] anchor_y;
    logic [spm_pkg::SUM_W-1:0]       group_sum;
    logic [CNT_W-1:0]                group_cnt;
    logic [spm_pkg::MD_W-1:0]        merge_radius;

    spm_in_if  pt_in();
    spm_out_if pt_out();

    stroke_point_merger_unit #(
        .COUNT_BITS (CNT_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_point       (pt_in),
        .o_point       (pt_out)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points outstanding",
                     cycle_count, kept_points_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void model_reset();
        pen_at_start = 1'b1;
        anchor_x     = '0;
        anchor_y     = '0;
        group_sum    = '0;
        group_cnt    = '0;
        merge_radius = '0;
    endfunction

    // Apply one accepted point to the model; return 1 when it is emitted
    function automatic bit merge_or_keep(input t_stroke_point pt, output t_stroke_point kept);
        longint                    dx;
        longint                    dy;
        longint                    d2;
        longint                    r2;
        logic [spm_pkg::SUM_W:0]   wide_sum;
        logic [spm_pkg::SUM_W-1:0] divisor;
        logic [spm_pkg::SUM_W-1:0] quot;
        kept = pt;
        // stroke end: emit as is and start over
        if (pt.last) begin
            pen_at_start = 1'b1;
            group_sum    = '0;
            group_cnt    = '0;
            return 1'b1;
        end
        if (!pen_at_start) begin
            dx = longint'(pt.x) - longint'(anchor_x);
            dy = longint'(pt.y) - longint'(anchor_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            d2 = dx * dx + dy * dy;
            r2 = longint'(merge_radius) * longint'(merge_radius);
            // inside the radius: drop the point, fold its pressure into the group
            if (d2 < r2) begin
                wide_sum  = {1'b0, group_sum} + (spm_pkg::SUM_W+1)'(pt.pressure);
                group_sum = wide_sum[spm_pkg::SUM_W] ? {spm_pkg::SUM_W{1'b1}}
                                                     : wide_sum[spm_pkg::SUM_W-1:0];
                if (group_cnt != {CNT_W{1'b1}}) group_cnt = group_cnt + 1'b1;
                return 1'b0;
            end
            // outside: emit with the average of the preceding group
            divisor = (group_cnt == '0) ? spm_pkg::SUM_W'(1) : spm_pkg::SUM_W'(group_cnt);
            quot    = group_sum / divisor;
            kept.pressure = (quot > {spm_pkg::P_W{1'b1}}) ? {spm_pkg::P_W{1'b1}}
                                                          : quot[spm_pkg::P_W-1:0];
        end
        pen_at_start = 1'b0;
        anchor_x     = pt.x;
        anchor_y     = pt.y;
        group_sum    = spm_pkg::SUM_W'(pt.pressure);
        group_cnt    = CNT_W'(1);
        return 1'b1;
    endfunction

    function automatic t_stroke_point pen_point(input longint x, input longint y,
                                                input int p, input bit last);
        t_stroke_point pt;
        pt.x        = x[spm_pkg::XY_W-1:0];
        pt.y        = y[spm_pkg::XY_W-1:0];
        pt.pressure = p[spm_pkg::P_W-1:0];
        pt.last     = last;
        return pt;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Send one request and record what it should produce
    task automatic send_point(input t_stroke_point pt);
        t_stroke_point kept;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pt_in.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        pt_in.valid      <= 1'b1;
        pt_in.point_x    <= pt.x;
        pt_in.point_y    <= pt.y;
        pt_in.pressure   <= pt.pressure;
        pt_in.stroke_end <= pt.last;
        do @(posedge i_clk); while (!pt_in.ready);
        if (merge_or_keep(pt, kept)) kept_points_q.push_back(kept);
    endtask

    // Hold the input idle until every expected point is out, then let a
    // dropped point finish its distance test
    task automatic drain_points();
        pt_in.valid <= 1'b0;
        while (kept_points_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [spm_pkg::MD_W-1:0] r);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        merge_radius = r;
    endtask

    // Stall the output side in random bursts
    initial begin : out_stall
        int stall_left;
        stall_left = 0;
        pt_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                pt_out.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 14);
                pt_out.ready <= 1'b0;
            end else begin
                pt_out.ready <= 1'b1;
            end
        end
    end

    // Compare each emitted point with the oldest expectation
    always @(posedge i_clk) begin : check_point
        t_stroke_point want;
        if (i_rst_n && pt_out.valid && pt_out.ready) begin
            if (kept_points_q.size() == 0) begin
                report_mismatch($sformatf("unexpected point x=%0d y=%0d p=%0d last=%0b",
                                pt_out.out_x, pt_out.out_y, pt_out.out_pressure,
                                pt_out.out_last));
            end else begin
                want = kept_points_q.pop_front();
                if (pt_out.out_x !== want.x)
                    report_mismatch($sformatf("out_x got %0d want %0d", pt_out.out_x, want.x));
                if (pt_out.out_y !== want.y)
                    report_mismatch($sformatf("out_y got %0d want %0d", pt_out.out_y, want.y));
                if (pt_out.out_pressure !== want.pressure)
                    report_mismatch($sformatf("out_pressure got %0d want %0d",
                                    pt_out.out_pressure, want.pressure));
                if (pt_out.out_last !== want.last)
                    report_mismatch($sformatf("out_last got %0b want %0b",
                                    pt_out.out_last, want.last));
            end
        end
    end

    // Radius left at its reset value of zero: nothing merges, even a repeat
    task automatic test_zero_radius();
        send_point(pen_point(0, 0, 1234, 1'b1));
        send_point(pen_point(XY_MIN, XY_MAX, 0, 1'b0));
        send_point(pen_point(XY_MIN, XY_MAX, 65535, 1'b0));
        send_point(pen_point(XY_MAX, XY_MIN, 65535, 1'b1));
        drain_points();
    endtask

    // Exactly on the radius emits, just inside merges
    task automatic test_radius_boundary();
        write_radius(spm_pkg::MD_W'(5));
        send_point(pen_point(100, 100, 1000, 1'b0));
        send_point(pen_point(103, 104, 2000, 1'b0));
        send_point(pen_point(107, 106, 4000, 1'b0));
        send_point(pen_point(107, 108, 3001, 1'b0));
        send_point(pen_point(107, 108, 7, 1'b1));
        drain_points();
    endtask

    // Largest radius against the widest coordinate span
    task automatic test_full_radius();
        write_radius({spm_pkg::MD_W{1'b1}});
        send_point(pen_point(XY_MIN, XY_MIN, 65535, 1'b0));
        send_point(pen_point(XY_MAX, XY_MAX, 65535, 1'b0));
        send_point(pen_point(0, 0, 65535, 1'b0));
        send_point(pen_point(4000000, 4000000, 1, 1'b0));
        send_point(pen_point(-4000000, -4000000, 2, 1'b0));
        send_point(pen_point(XY_MAX, XY_MIN, 0, 1'b0));
        send_point(pen_point(5, 5, 9, 1'b1));
        send_point(pen_point(1, -1, 77, 1'b1));
        drain_points();
    endtask

    function automatic longint rand_coord();
        logic signed [spm_pkg::XY_W-1:0] c;
        c = spm_pkg::XY_W'($urandom);
        return longint'(c);
    endfunction

    function automatic longint clamp_xy(input longint v);
        if (v > XY_MAX) return XY_MAX;
        if (v < XY_MIN) return XY_MIN;
        return v;
    endfunction

    function automatic logic [spm_pkg::MD_W-1:0] phase_radius(input int k);
        case (k)
            0:       return spm_pkg::MD_W'(1);
            1:       return spm_pkg::MD_W'(256);
            2:       return spm_pkg::MD_W'($urandom_range(0, 4096));
            3:       return spm_pkg::MD_W'(2560);
            4:       return spm_pkg::MD_W'($urandom_range(0, 32'h7FFFFF));
            5:       return {spm_pkg::MD_W{1'b1}};
            6:       return '0;
            default: return spm_pkg::MD_W'($urandom_range(1, 1000));
        endcase
    endfunction

    // One stroke: a random walk from a random start point, or scattered noise
    task automatic send_stroke(input longint span, input bit noisy, inout int sent);
        int     len;
        longint px;
        longint py;
        len = $urandom_range(1, 24);
        px  = rand_coord();
        py  = rand_coord();
        for (int i = 0; i < len; i++) begin
            if (noisy) begin
                px = rand_coord();
                py = rand_coord();
            end else if (i > 0) begin
                px = clamp_xy(px + longint'($urandom_range(0, 2 * span)) - span);
                py = clamp_xy(py + longint'($urandom_range(0, 2 * span)) - span);
            end
            send_point(pen_point(px, py, $urandom_range(0, 65535),
                       noisy ? ($urandom_range(0, 7) == 0) : (i == len - 1)));
        end
        sent += len;
    endtask

    task automatic test_random_strokes();
        int     sent;
        longint r;
        longint span;
        for (int k = 0; k < PHASES; k++) begin
            drain_points();
            write_radius(phase_radius(k));
            r    = longint'(merge_radius);
            sent = 0;
            while (sent < PHASE_POINTS) begin
                // last phase runs without any idling
                idle_on <= (k == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 3))
                    0:       span = r / 2;
                    1:       span = r;
                    2:       span = 2 * r + 16;
                    default: span = 3;
                endcase
                send_stroke(span, $urandom_range(0, 4) == 0, sent);
            end
        end
    endtask

    initial begin : main
        i_rst_n          <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        pt_in.valid      <= 1'b0;
        pt_in.point_x    <= '0;
        pt_in.point_y    <= '0;
        pt_in.pressure   <= '0;
        pt_in.stroke_end <= 1'b0;
        idle_on          <= 1'b1;
        model_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_radius();
        test_radius_boundary();
        test_full_radius();
        test_random_strokes();
        drain_points();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ stroke_point_merger_unit.f @@
rtl/spm_pkg.sv
rtl/spm_ifs.sv
rtl/spm_dist.sv
rtl/spm_div.sv
rtl/stroke_point_merger_unit.sv
verif/tb.sv
